>>> hw/rtl/dmrc_pkg.sv
// Package for the downmix and rate converter: shared constants, register
// codes, the back-end state type, queue status and the reciprocal table.
// No dependencies.
package dmrc_pkg;

  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned CH_W          = 5;   // holds an effective channel count up to 16
  localparam int unsigned IN_RATE_W     = 17;
  localparam int unsigned OUT_RATE_W    = 16;
  localparam int unsigned CH_REG_W      = 4;
  localparam int unsigned ACC_W         = 18;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 17;
  localparam int unsigned DEF_MAX_CHANNELS = 8;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned MAX_COPIES    = 6;
  localparam int unsigned COPY_CNT_W    = 3;
  localparam int unsigned RECIP_W       = 24;
  // Quotient = (|sum| * ceil(2^23 / c)) >> 23 is exact for |sum| < 2^19, c <= 16.
  localparam int unsigned RECIP_SHIFT   = 23;

  localparam logic [IN_RATE_W-1:0]  RST_SRC_RATE  = 17'd44100;
  localparam logic [OUT_RATE_W-1:0] RST_DST_RATE  = 16'd48000;
  localparam logic [CH_REG_W-1:0]   RST_CHANNELS  = 4'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_RATE      = 2'd0,
    REG_DST_RATE      = 2'd1,
    REG_CHANNEL_COUNT = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_EMIT,
    BK_MOD
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // A channel count of zero acts as one; above the build limit it is clamped.
  function automatic logic [CH_W-1:0] eff_chans(input logic [CH_REG_W-1:0] c,
                                                input int unsigned maxc);
    logic [CH_W-1:0] r;
    r = (c == '0) ? CH_W'(1) : CH_W'(c);
    if (32'(r) > maxc) r = CH_W'(maxc);
    return r;
  endfunction

  function automatic logic [RECIP_W-1:0] recip(input logic [CH_W-1:0] c);
    logic [RECIP_W-1:0] m;
    case (c)
      5'd2:    m = 24'd4194304;
      5'd3:    m = 24'd2796203;
      5'd4:    m = 24'd2097152;
      5'd5:    m = 24'd1677722;
      5'd6:    m = 24'd1398102;
      5'd7:    m = 24'd1198373;
      5'd8:    m = 24'd1048576;
      5'd9:    m = 24'd932068;
      5'd10:   m = 24'd838861;
      5'd11:   m = 24'd762601;
      5'd12:   m = 24'd699051;
      5'd13:   m = 24'd645278;
      5'd14:   m = 24'd599187;
      5'd15:   m = 24'd559241;
      5'd16:   m = 24'd524288;
      default: m = 24'd8388608;
    endcase
    return m;
  endfunction

endpackage

>>> hw/rtl/dmrc_front.sv
// Front end of the downmix and rate converter: accepts interleaved samples,
// sums each frame and pushes completed frame sums into the queue.
// Depends on dmrc_pkg.
module dmrc_front #(
  parameter int unsigned MAX_CHANNELS = dmrc_pkg::DEF_MAX_CHANNELS,
  parameter int unsigned SUM_W        = dmrc_pkg::SAMPLE_W + $clog2(MAX_CHANNELS)
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 clear,
  input  logic [dmrc_pkg::CH_REG_W-1:0]        channel_count,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [dmrc_pkg::SAMPLE_W-1:0]        in_tdata,
  input  logic                                 in_tlast,
  input  dmrc_pkg::queue_stat_t                q_stat,
  output logic                                 push,
  output logic [SUM_W-1:0]                     push_data
);
  import dmrc_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_CHANNELS + 1);

  logic signed [SUM_W-1:0] sum_r, sum_nxt, sum_add;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [CH_W-1:0]         chans;
  logic                    accept, frame_done;
  logic signed [SAMPLE_W-1:0] sample;

  assign chans      = eff_chans(channel_count, MAX_CHANNELS);
  assign in_tready  = !q_stat.full;
  assign accept     = in_tvalid && in_tready;
  assign sample     = signed'(in_tdata);
  assign sum_add    = sum_r + SUM_W'(sample);
  assign frame_done = (CH_W'(idx_r) + CH_W'(1)) >= chans;
  assign push       = accept && frame_done;
  assign push_data  = sum_add;

  always_comb begin
    sum_nxt = sum_r;
    idx_nxt = idx_r;
    if (accept) begin
      // A block end drops an unfinished frame.
      if (frame_done || in_tlast) begin
        sum_nxt = '0;
        idx_nxt = '0;
      end else begin
        sum_nxt = sum_add;
        idx_nxt = idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      sum_r <= '0;
      idx_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      idx_r <= idx_nxt;
    end
  end

endmodule

>>> hw/rtl/dmrc_queue.sv
// Short queue of completed frame sums between front and back end.
// Depends on dmrc_pkg.
module dmrc_queue #(
  parameter int unsigned WIDTH = dmrc_pkg::SAMPLE_W,
  parameter int unsigned DEPTH = dmrc_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [WIDTH-1:0]      push_data,
  input  logic                  pop,
  output logic [WIDTH-1:0]      head,
  output dmrc_pkg::queue_stat_t stat
);
  import dmrc_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (32'(p) == DEPTH - 1) ? '0 : p + PTR_W'(1);
  endfunction

  assign head       = entries[rd_r];
  assign stat.full  = (32'(cnt_r) == DEPTH);
  assign stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) entries[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= ptr_inc(wr_r);
      if (pop)  rd_r <= ptr_inc(rd_r);
      if (push && !pop)      cnt_r <= cnt_r + CNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

endmodule

>>> hw/rtl/dmrc_back.sv
// Back end of the downmix and rate converter: divides each frame sum by the
// channel count, steps the rate accumulator and emits the output copies.
// Depends on dmrc_pkg.
module dmrc_back #(
  parameter int unsigned MAX_CHANNELS = dmrc_pkg::DEF_MAX_CHANNELS,
  parameter int unsigned SUM_W        = dmrc_pkg::SAMPLE_W + $clog2(MAX_CHANNELS)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              clear,
  input  logic [dmrc_pkg::IN_RATE_W-1:0]    src_rate,
  input  logic [dmrc_pkg::OUT_RATE_W-1:0]   dst_rate,
  input  logic [dmrc_pkg::CH_REG_W-1:0]     channel_count,
  input  dmrc_pkg::queue_stat_t             q_stat,
  input  logic [SUM_W-1:0]                  head,
  output logic                              pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [dmrc_pkg::SAMPLE_W-1:0]     out_tdata,   // mono_out
  output logic                              out_tlast    // run_last
);
  import dmrc_pkg::*;

  localparam int unsigned PROD_W = SUM_W + RECIP_W;
  localparam int unsigned MOD_CNT_W = $clog2(ACC_W);

  back_state_t            state_r, state_nxt;
  logic [ACC_W-1:0]       acc_r, acc_nxt;
  logic [SUM_W-1:0]       mag_r, mag_nxt;
  logic                   neg_r, neg_nxt;
  logic [PROD_W-1:0]      prod_r, prod_nxt;
  logic [COPY_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IN_RATE_W-1:0]   rem_r, rem_nxt;
  logic [MOD_CNT_W-1:0]   bit_r, bit_nxt;
  logic                   ovld_r, ovld_nxt;
  logic [SAMPLE_W-1:0]    odata_r, odata_nxt;
  logic                   olast_r, olast_nxt;

  logic [ACC_W-1:0]       in_ext, acc_sub, rem_shift;
  logic                   acc_ge, out_free;
  logic [SAMPLE_W-1:0]    quot, mono;

  assign in_ext    = ACC_W'(src_rate);
  assign acc_ge    = (src_rate != '0) && (acc_r >= in_ext);
  assign acc_sub   = acc_r - in_ext;
  assign out_free  = !ovld_r || out_tready;
  assign quot      = prod_r[RECIP_SHIFT +: SAMPLE_W];
  assign mono      = neg_r ? (SAMPLE_W'(0) - quot) : quot;
  assign rem_shift = {rem_r, acc_r[ACC_W-1]};

  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    prod_nxt  = prod_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    bit_nxt   = bit_r;
    odata_nxt = odata_r;
    olast_nxt = olast_r;
    ovld_nxt  = ovld_r && !out_tready;
    pop       = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          pop     = 1'b1;
          neg_nxt = head[SUM_W-1];
          mag_nxt = head[SUM_W-1] ? (SUM_W'(0) - head) : head;
          acc_nxt = (src_rate == '0) ? '0 : acc_r + ACC_W'(dst_rate);
          state_nxt = BK_MUL;
        end
      end
      BK_MUL: begin
        prod_nxt  = PROD_W'(mag_r) * PROD_W'(recip(eff_chans(channel_count, MAX_CHANNELS)));
        cnt_nxt   = '0;
        state_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (!acc_ge) begin
          state_nxt = BK_IDLE;
        end else if (32'(cnt_r) == MAX_COPIES) begin
          // Copies beyond the limit are dropped: reduce the accumulator modulo
          // the input rate, one bit per cycle.
          rem_nxt   = '0;
          bit_nxt   = '0;
          state_nxt = BK_MOD;
        end else if (out_free) begin
          acc_nxt   = acc_sub;
          ovld_nxt  = 1'b1;
          odata_nxt = mono;
          olast_nxt = (acc_sub < in_ext) || (32'(cnt_r) == MAX_COPIES - 1);
          cnt_nxt   = cnt_r + COPY_CNT_W'(1);
        end
      end
      BK_MOD: begin
        rem_nxt = (rem_shift >= in_ext) ? IN_RATE_W'(rem_shift - in_ext)
                                        : IN_RATE_W'(rem_shift);
        acc_nxt = {acc_r[ACC_W-2:0], 1'b0};
        bit_nxt = bit_r + MOD_CNT_W'(1);
        if (32'(bit_r) == ACC_W - 1) begin
          acc_nxt   = ACC_W'(rem_nxt);
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
    if (clear) acc_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      acc_r   <= '0;
      ovld_r  <= 1'b0;
      cnt_r   <= '0;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      ovld_r  <= ovld_nxt;
      cnt_r   <= cnt_nxt;
      bit_r   <= bit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r   <= mag_nxt;
    neg_r   <= neg_nxt;
    prod_r  <= prod_nxt;
    rem_r   <= rem_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
  end

endmodule

>>> hw/rtl/downmix_and_rate_convert.sv
// Downmix and rate converter, top level: configuration registers, front end,
// frame queue and back end. Depends on dmrc_pkg and the dmrc_* modules.
// A frame sum is queued; its magnitude, product and copies are then registered,
// and a copy may wait for out_tready. Throughput: one sample per cycle into the
// front while the queue is not full; the back end takes one frame at a time.
// Synchronous reset (rst_n low) restores defaults and clears the control state.
module downmix_and_rate_convert #(
  parameter int unsigned MAX_CHANNELS = dmrc_pkg::DEF_MAX_CHANNELS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [dmrc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dmrc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [dmrc_pkg::SAMPLE_W-1:0]     in_tdata,   // sample_in
  input  logic                              in_tlast,   // block_end
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [dmrc_pkg::SAMPLE_W-1:0]     out_tdata,  // mono_out
  output logic                              out_tlast   // run_last
);
  import dmrc_pkg::*;

  localparam int unsigned SUM_W = SAMPLE_W + $clog2(MAX_CHANNELS);

  logic [IN_RATE_W-1:0]  src_rate_r;
  logic [OUT_RATE_W-1:0] dst_rate_r;
  logic [CH_REG_W-1:0]   channels_r;
  logic                  clear;
  logic                  push, pop;
  logic [SUM_W-1:0]      push_data, head;
  queue_stat_t           q_stat;

  always_comb begin
    unique case (cfg_index)
      REG_SRC_RATE, REG_DST_RATE, REG_CHANNEL_COUNT: clear = cfg_we;
      default: clear = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_rate_r <= RST_SRC_RATE;
      dst_rate_r <= RST_DST_RATE;
      channels_r <= RST_CHANNELS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_RATE:      src_rate_r <= cfg_wdata[IN_RATE_W-1:0];
        REG_DST_RATE:      dst_rate_r <= cfg_wdata[OUT_RATE_W-1:0];
        REG_CHANNEL_COUNT: channels_r <= cfg_wdata[CH_REG_W-1:0];
        default: ;
      endcase
    end
  end

  dmrc_front #(.MAX_CHANNELS(MAX_CHANNELS), .SUM_W(SUM_W)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .clear        (clear),
    .channel_count(channels_r),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .q_stat       (q_stat),
    .push         (push),
    .push_data    (push_data)
  );

  dmrc_queue #(.WIDTH(SUM_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  dmrc_back #(.MAX_CHANNELS(MAX_CHANNELS), .SUM_W(SUM_W)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .clear        (clear),
    .src_rate     (src_rate_r),
    .dst_rate     (dst_rate_r),
    .channel_count(channels_r),
    .q_stat       (q_stat),
    .head         (head),
    .pop          (pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full) else $error("frame queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty) else $error("frame queue underflow");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("output valid right after reset");

  a_zero_rate_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (src_rate_r == '0) && !out_tvalid |=> !out_tvalid)
    else $error("copy emitted with zero input rate");

endmodule
